// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted insert priority queue.
// No dependencies; used by spq_cell and sorted_insert_priority_queue_unit.
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CODE_W = 16;
    localparam int PRIO_W = 8;
    localparam int FILL_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DUMP   = 2'd2,
        OP_NONE   = 2'd3
    } spq_op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_GIVEN    = 2'd3
    } spq_status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2,
        CMD_ROTATE = 2'd3
    } spq_cmd_t;

    typedef struct packed {
        logic              vld;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
    } spq_entry_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, shifts toward either neighbor.
// Depends on spq_pkg.
module spq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::spq_cmd_t   cmd,
    input  spq_pkg::spq_entry_t new_entry,
    input  spq_pkg::spq_entry_t front_entry,
    input  spq_pkg::spq_entry_t left_entry,
    input  logic                left_gt,
    input  spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t entry,
    output logic                gt
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // entry sorts strictly after the new one
    assign gt    = entry_reg.vld && (entry_reg.prio > new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd)
            spq_pkg::CMD_HOLD:
            begin
                entry_next = entry_reg;
            end
            spq_pkg::CMD_INSERT:
            begin
                if (left_gt)
                begin
                    entry_next = left_entry;
                end
                else if (gt || (!entry_reg.vld && left_entry.vld))
                begin
                    entry_next     = new_entry;
                    entry_next.vld = 1'b1;
                end
            end
            spq_pkg::CMD_POP:
            begin
                entry_next = right_entry;
            end
            spq_pkg::CMD_ROTATE:
            begin
                if (right_entry.vld)
                begin
                    entry_next = right_entry;
                end
                else if (entry_reg.vld)
                begin
                    entry_next = front_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- rtl/core/sorted_insert_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Sorted insert priority queue: top level with control and output register.
// Depends on spq_pkg and spq_cell.
//
// Bounded queue of (code, priority) entries kept in ascending priority, with
// equal priorities in arrival order, held in a chain of cells that all compare
// against the new entry at once. Insert and pop each give one result and an
// unused operation gives none; a dump emits every stored entry in turn (one
// empty result when empty), with the input stalled meanwhile, since the chain
// rotates by one cell per emitted entry and ends back in order.
// A result sits in an output register; the input stalls while it waits and the
// next transfer is accepted in the cycle it leaves. Every result carries the
// fill level after the operation.
module sorted_insert_priority_queue_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   operation,
    input  logic [spq_pkg::CODE_W-1:0]   code,
    input  logic [spq_pkg::PRIO_W-1:0]   priority_req,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [spq_pkg::CODE_W-1:0]   out_code,
    output logic [spq_pkg::PRIO_W-1:0]   out_priority,
    output logic                         last,
    output logic [spq_pkg::FILL_W-1:0]   fill
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic [spq_pkg::CNT_W-1:0] remain_reg;
    logic [spq_pkg::CNT_W-1:0] remain_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    spq_pkg::spq_status_t        status_reg;
    spq_pkg::spq_status_t        status_next;
    logic [spq_pkg::CODE_W-1:0]  code_reg;
    logic [spq_pkg::CODE_W-1:0]  code_next;
    logic [spq_pkg::PRIO_W-1:0]  prio_reg;
    logic [spq_pkg::PRIO_W-1:0]  prio_next;
    logic                        last_reg;
    logic                        last_next;
    logic [spq_pkg::CNT_W-1:0]   fill_reg;
    logic [spq_pkg::CNT_W-1:0]   fill_next;

    spq_pkg::spq_cmd_t   cmd;
    spq_pkg::spq_entry_t new_entry;
    spq_pkg::spq_entry_t cell_q [spq_pkg::DEPTH];
    logic                cell_gt [spq_pkg::DEPTH];

    logic            slot_free;
    logic            take;
    logic            full;
    logic            empty;
    logic            out_load;
    spq_pkg::spq_op_t op;

    assign op        = spq_pkg::spq_op_t'(operation);
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !slot_free;
    assign take      = in_valid && !in_stall;
    assign full      = cell_q[spq_pkg::DEPTH-1].vld;
    assign empty     = !cell_q[0].vld;

    assign new_entry.vld  = 1'b1;
    assign new_entry.code = code;
    assign new_entry.prio = priority_req;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        cmd         = spq_pkg::CMD_HOLD;
        out_load    = 1'b0;
        status_next = spq_pkg::ST_INSERTED;
        code_next   = '0;
        prio_next   = '0;
        last_next   = 1'b1;
        fill_next   = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (op)
                        spq_pkg::OP_INSERT:
                        begin
                            out_load = 1'b1;
                            if (full)
                            begin
                                status_next = spq_pkg::ST_DROPPED;
                            end
                            else
                            begin
                                cmd         = spq_pkg::CMD_INSERT;
                                count_next  = count_reg + spq_pkg::CNT_W'(1);
                                fill_next   = count_next;
                                status_next = spq_pkg::ST_INSERTED;
                            end
                        end
                        spq_pkg::OP_POP:
                        begin
                            out_load = 1'b1;
                            if (empty)
                            begin
                                status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd         = spq_pkg::CMD_POP;
                                count_next  = count_reg - spq_pkg::CNT_W'(1);
                                fill_next   = count_next;
                                status_next = spq_pkg::ST_GIVEN;
                                code_next   = cell_q[0].code;
                                prio_next   = cell_q[0].prio;
                            end
                        end
                        spq_pkg::OP_DUMP:
                        begin
                            if (empty)
                            begin
                                out_load    = 1'b1;
                                status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                remain_next = count_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        spq_pkg::OP_NONE:
                        begin
                            out_load = 1'b0;
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    cmd         = spq_pkg::CMD_ROTATE;
                    out_load    = 1'b1;
                    status_next = spq_pkg::ST_GIVEN;
                    code_next   = cell_q[0].code;
                    prio_next   = cell_q[0].prio;
                    last_next   = (remain_reg == spq_pkg::CNT_W'(1));
                    remain_next = remain_reg - spq_pkg::CNT_W'(1);
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::DEPTH; gi++)
        begin : g_cell
            spq_pkg::spq_entry_t left_entry;
            spq_pkg::spq_entry_t right_entry;
            logic                left_gt;

            if (gi == 0)
            begin : g_head
                // head sees an always-present, never-greater left neighbor
                assign left_entry.vld  = 1'b1;
                assign left_entry.code = '0;
                assign left_entry.prio = '0;
                assign left_gt         = 1'b0;
            end
            else
            begin : g_body
                assign left_entry = cell_q[gi-1];
                assign left_gt    = cell_gt[gi-1];
            end

            if (gi == spq_pkg::DEPTH - 1)
            begin : g_tail
                assign right_entry.vld  = 1'b0;
                assign right_entry.code = '0;
                assign right_entry.prio = '0;
            end
            else
            begin : g_mid
                assign right_entry = cell_q[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .new_entry   (new_entry),
                .front_entry (cell_q[0]),
                .left_entry  (left_entry),
                .left_gt     (left_gt),
                .right_entry (right_entry),
                .entry       (cell_q[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            code_reg   <= code_next;
            prio_reg   <= prio_next;
            last_reg   <= last_next;
            fill_reg   <= fill_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_code     = code_reg;
    assign out_priority = prio_reg;
    assign last         = last_reg;
    assign fill         = spq_pkg::FILL_W'(fill_reg);

endmodule
